/* rtl/lkvc_pkg.sv */
// Package for the LRU key-value cache: table geometry, operation codes,
// and the transaction structs shared by the table and the top level.
// No dependencies.
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W     = IDX_W;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [VAL_W-1:0] RD_MISS   = '1;

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } op_t;

  typedef struct packed {
    logic              hit;
    logic [VAL_W-1:0]  read_value;
  } res_t;

endpackage

/* rtl/lru_key_value_cache_unit.sv */
// LRU key-value cache: a fully associative table of 16 entries.
//
// Input channel s_*: one get or put per transaction. s_tuser carries the
// kind (0 get, 1 put); s_tdata carries key in [31:0] and value in [63:32].
// Output channel m_*: exactly one result per input, in order. m_tuser is
// hit (key present before the operation); m_tdata is the stored value on a
// get hit and all ones otherwise.
// Config channel cfg_*: writes the capacity register (reset 16, values
// above 16 act as 16). Write it only while no transaction is in flight.
//
// An accepted item is held in the input register; once the output is free, the
// lookup, recency update and evict/insert are done in one pass into the result
// register, and m_tvalid rises with it. Throughput is one transaction per cycle
// while m_tready is high, set by that single pass.
// A stalled m_tready holds the result and the item behind it; s_tready
// drops once both registers are full.
// Synchronous reset empties the table and both registers; capacity returns
// to 16.
// Depends on lkvc_pkg and lkvc_table.
`timescale 1ns / 1ps

module lru_key_value_cache_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value
  input  logic [0:0]  s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] read_value
  output logic [0:0]  m_tuser,   // [0] hit
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);
  import lkvc_pkg::*;

  logic               in_valid;
  op_t                in_op;
  logic               adv;
  logic [CAP_W-1:0]   capacity;
  res_t               res;

  assign adv       = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op.kind  <= kind_t'(s_tuser[0]);
      in_op.key   <= s_tdata[31:0];
      in_op.value <= s_tdata[63:32];
    end
  end

  lkvc_table u_table (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .op       (in_op),
    .capacity (capacity),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata    <= res.read_value;
      m_tuser[0] <= res.hit;
    end
  end

endmodule

/* rtl/lkvc_table.sv */
// Entry table of the LRU key-value cache: keys, values, valid bits and
// recency ranks, with the lookup, touch, insert and evict.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_table (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  lkvc_pkg::op_t         op,
  input  logic [lkvc_pkg::CAP_W-1:0] capacity,
  output lkvc_pkg::res_t        res
);
  import lkvc_pkg::*;

  logic [ENTRIES-1:0]   valid;
  logic [ENTRIES-1:0]   valid_next;
  logic [AGE_W-1:0]     age      [ENTRIES];
  logic [AGE_W-1:0]     age_next [ENTRIES];
  logic [KEY_W-1:0]     key_mem  [ENTRIES];
  logic [VAL_W-1:0]     val_mem  [ENTRIES];
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;

  logic [ENTRIES-1:0]   match;
  logic [ENTRIES-1:0]   wr_key;
  logic [ENTRIES-1:0]   wr_val;
  logic [ENTRIES-1:0]   evict_oh;
  logic [ENTRIES-1:0]   vpre;
  logic [ENTRIES-1:0]   slot_oh;
  logic [AGE_W-1:0]     tage     [ENTRIES];
  logic [VAL_W-1:0]     rd_sel;
  logic [AGE_W-1:0]     a_sel;
  logic [AGE_W-1:0]     count_m1;
  logic [CNT_W-1:0]     cap_eff;
  logic                 hit;
  logic                 full;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid[i] && (key_mem[i] == op.key);
    end
  end

  always_comb begin
    rd_sel = '0;
    a_sel  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        rd_sel = rd_sel | val_mem[i];
        a_sel  = a_sel | age[i];
      end
    end
  end

  assign hit      = |match;
  assign count_m1 = AGE_W'(count - CNT_W'(1));
  assign full     = (count >= cap_eff);

  always_comb begin
    if (32'(capacity) >= 32'(ENTRIES)) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  // Move the hit entry to rank 0; everything younger ages by one.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        tage[i] = '0;
      end else if (valid[i] && (age[i] < a_sel)) begin
        tage[i] = age[i] + AGE_W'(1);
      end else begin
        tage[i] = age[i];
      end
    end
  end

  // On a miss that overflows, the oldest entry leaves before the insert.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      evict_oh[i] = full && (count != '0) && valid[i] && (age[i] == count_m1);
    end
  end

  assign vpre    = valid & ~evict_oh;
  assign slot_oh = ~vpre & (vpre + ENTRIES'(1));

  always_comb begin
    valid_next = valid;
    count_next = count;
    wr_key     = '0;
    wr_val     = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      age_next[i] = age[i];
    end
    if (en) begin
      unique case (op.kind)
        KIND_GET: begin
          if (hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
              age_next[i] = tage[i];
            end
          end
        end
        KIND_PUT: begin
          if (hit) begin
            wr_val = match;
            for (int i = 0; i < ENTRIES; i++) begin
              age_next[i] = tage[i];
            end
            // Capacity may have been lowered: drop one oldest entry per put hit.
            if (count > cap_eff) begin
              for (int i = 0; i < ENTRIES; i++) begin
                if (valid[i] && (tage[i] == count_m1)) begin
                  valid_next[i] = 1'b0;
                  age_next[i]   = '0;
                end
              end
              count_next = count - CNT_W'(1);
            end
          end else if ((cap_eff != '0) || (count != '0)) begin
            wr_key = slot_oh;
            wr_val = slot_oh;
            for (int i = 0; i < ENTRIES; i++) begin
              if (slot_oh[i]) begin
                valid_next[i] = 1'b1;
                age_next[i]   = '0;
              end else if (vpre[i]) begin
                age_next[i] = age[i] + AGE_W'(1);
              end else if (evict_oh[i]) begin
                valid_next[i] = 1'b0;
                age_next[i]   = '0;
              end
            end
            if (!full) begin
              count_next = count + CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age[i] <= '0;
      end
    end else begin
      valid <= valid_next;
      count <= count_next;
      for (int i = 0; i < ENTRIES; i++) begin
        age[i] <= age_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_key[i]) begin
        key_mem[i] <= op.key;
      end
      if (wr_val[i]) begin
        val_mem[i] <= op.value;
      end
    end
  end

  always_comb begin
    res.hit = hit;
    if ((op.kind == KIND_GET) && hit) begin
      res.read_value = rd_sel;
    end else begin
      res.read_value = RD_MISS;
    end
  end

endmodule

/* rtl/lkvc_checker.sv */
// Port-level checks for the LRU key-value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache_unit.
`timescale 1ns / 1ps

module lkvc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);
  import lkvc_pkg::*;

  // Reset leaves no result pending.
  a_rst_out_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Reset leaves the input side open.
  a_rst_in_open: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready right after reset");

  // A result without hit always reports all ones.
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tuser[0]) |-> (m_tdata == RD_MISS))
    else $error("result without hit carries a stored value");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed or dropped");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (.*);

/* verif/tb_top.sv */
// Self-checking testbench for lru_key_value_cache_unit: directed and random get/put traffic
// with random stalls on both stream sides, checked against an in-bench LRU table model.
// Depends on lkvc_pkg and the RTL of the cache unit.
`timescale 1ns / 1ps

module tb_top;
  import lkvc_pkg::*;

  // Mirror of the cache table; predicts hit and read_value for each accepted access.
  class lru_scoreboard;
    bit               slot_used [ENTRIES];
    logic [KEY_W-1:0] slot_key  [ENTRIES];
    logic [VAL_W-1:0] slot_val  [ENTRIES];
    int unsigned      slot_rank [ENTRIES];
    int unsigned      held;
    logic [CAP_W-1:0] capacity;
    res_t             awaited_lookups [$];
    int               errors;
    int               accesses;
    int               hits;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
        slot_val[i]  = '0;
        slot_rank[i] = 0;
      end
      held     = 0;
      capacity = CAP_RESET;
      errors   = 0;
      accesses = 0;
      hits     = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    function int outstanding();
      return awaited_lookups.size();
    endfunction

    function int find_slot(logic [KEY_W-1:0] k);
      for (int i = 0; i < ENTRIES; i++)
        if (slot_used[i] && slot_key[i] == k)
          return i;
      return -1;
    endfunction

    // Make slot e the most recent; every younger entry ages by one.
    function void promote(int e);
      int unsigned r;
      r = slot_rank[e];
      for (int i = 0; i < ENTRIES; i++)
        if (slot_used[i] && slot_rank[i] < r)
          slot_rank[i]++;
      slot_rank[e] = 0;
    endfunction

    function void drop_oldest();
      if (held == 0)
        return;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_used[i] && slot_rank[i] == held - 1) begin
          slot_used[i] = 1'b0;
          slot_rank[i] = 0;
          held--;
          return;
        end
      end
    endfunction

    function void insert_fresh(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      int slot;
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_used[i])
          slot_rank[i]++;
        else if (slot < 0)
          slot = i;
      end
      if (slot < 0)
        return;
      slot_used[slot] = 1'b1;
      slot_key[slot]  = k;
      slot_val[slot]  = v;
      slot_rank[slot] = 0;
      held++;
    endfunction

    function res_t lru_access(kind_t kind, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      res_t        r;
      int          e;
      int unsigned lim;
      lim = (capacity < ENTRIES) ? capacity : ENTRIES;
      e = find_slot(k);
      r.hit        = (e >= 0);
      r.read_value = RD_MISS;
      if (kind == KIND_GET) begin
        if (e >= 0) begin
          r.read_value = slot_val[e];
          promote(e);
        end
      end else if (e >= 0) begin
        slot_val[e] = v;
        promote(e);
        if (held > lim)
          drop_oldest();
      end else if (held + 1 > lim) begin
        // Table over the limit: the oldest goes, the new key takes its place.
        if (held > 0) begin
          drop_oldest();
          insert_fresh(k, v);
        end
      end else begin
        insert_fresh(k, v);
      end
      return r;
    endfunction

    function void note_access(kind_t kind, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      res_t r;
      r = lru_access(kind, k, v);
      awaited_lookups.push_back(r);
      accesses++;
      if (r.hit)
        hits++;
    endfunction

    function void check_response(logic hit, logic [VAL_W-1:0] rd);
      res_t want;
      if (awaited_lookups.size() == 0) begin
        $error("unexpected result: hit %0b read_value %h", hit, rd);
        errors++;
        return;
      end
      want = awaited_lookups.pop_front();
      if (hit !== want.hit) begin
        $error("hit: expected %0b, got %0b", want.hit, hit);
        errors++;
      end
      if (rd !== want.read_value) begin
        $error("read_value: expected %h, got %h", want.read_value, rd);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // [31:0] key, [63:32] value
  logic [0:0]  s_tuser = '0;   // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] read_value
  logic [0:0]  m_tuser;        // [0] hit
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  int phases    = 0;

  lru_scoreboard chk = new();

  lru_key_value_cache_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Result side: check each transaction, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      chk.check_response(m_tuser[0], m_tdata);
    m_tready <= !(stalls_on && ($urandom_range(0, 99) < 36));
  end

  task automatic send_access(input kind_t kind, input logic [KEY_W-1:0] k,
                             input logic [VAL_W-1:0] v);
    while (gaps_on && ($urandom_range(0, 99) < 36)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {v, k};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    chk.note_access(kind, k, v);
  endtask

  // Hold off input until every result is back.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (chk.outstanding() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    chk.set_capacity(c);
    phases++;
  endtask

  task automatic random_phase(input logic [CAP_W-1:0] c, input int n, input bit pause_mid);
    logic [KEY_W-1:0] pool [24];
    int               pool_n;
    logic [KEY_W-1:0] k;
    kind_t            kind;
    write_capacity(c);
    pool_n = $urandom_range(2, 24);
    for (int i = 0; i < 24; i++)
      pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2)
        settle();
      if ($urandom_range(0, 99) < 85)
        k = pool[$urandom_range(0, pool_n - 1)];
      else
        k = $urandom;
      kind = $urandom_range(0, 1) ? KIND_PUT : KIND_GET;
      send_access(kind, k, $urandom);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table, extreme keys and values, update of a present key.
    write_capacity(5'd16);
    send_access(KIND_GET, 32'h0000_0000, 32'h0000_0000);
    send_access(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_access(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_access(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
    send_access(KIND_GET, 32'h8000_0000, 32'h1111_1111);
    send_access(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_access(KIND_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
    send_access(KIND_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_access(KIND_GET, 32'h0000_0001, 32'h0000_0000);

    // Capacity dropped below the count: gets keep entries, present-key puts shrink by one.
    write_capacity(5'd2);
    send_access(KIND_GET, 32'h0000_0000, 32'h0000_0000);
    send_access(KIND_PUT, 32'h8000_0000, 32'h0000_0005);
    send_access(KIND_PUT, 32'h0000_0055, 32'hA5A5_A5A5);
    send_access(KIND_PUT, 32'h8000_0000, 32'h0000_0006);
    send_access(KIND_GET, 32'h0000_0055, 32'h0000_0000);

    // Capacity zero: present-key puts drain the table, then inserts are dropped.
    write_capacity(5'd0);
    send_access(KIND_PUT, 32'hAAAA_AAAA, 32'h0000_0001);
    send_access(KIND_PUT, 32'h0000_0055, 32'h0000_0002);
    send_access(KIND_PUT, 32'hAAAA_AAAA, 32'h0000_0003);
    send_access(KIND_PUT, 32'h0000_0055, 32'h0000_0004);
    send_access(KIND_PUT, 32'h0000_0055, 32'h0000_0005);
    send_access(KIND_GET, 32'h0000_0055, 32'h0000_0000);
    send_access(KIND_PUT, 32'h0000_1234, 32'h0000_0007);
    send_access(KIND_GET, 32'h0000_1234, 32'h0000_0000);

    // Random traffic over a spread of capacities, above the table size included.
    random_phase(5'd31, 60, 1'b0);
    random_phase(5'd1, 60, 1'b0);
    random_phase(5'd4, 60, 1'b1);
    random_phase(5'd0, 50, 1'b0);
    random_phase(5'd2, 60, 1'b0);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    random_phase(5'd16, 70, 1'b0);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    random_phase(5'd17, 60, 1'b0);
    random_phase(5'($urandom_range(0, 31)), 60, 1'b0);

    settle();
    repeat (10) @(posedge clk);
    $display("Checked %0d get/put transactions, %0d of them hits, across %0d capacity settings.",
             chk.accesses, chk.hits, phases);
    if (chk.errors == 0 && chk.outstanding() == 0)
      $display("[lru_key_value_cache_unit] OK");
    else
      $display("[lru_key_value_cache_unit] ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[lru_key_value_cache_unit] ERROR");
    $finish;
  end

endmodule
